[rtl/cobs_crc16_frame_decoder_macros.svh]
// ----------------------------------------------------------------------------
// cobs_crc16_frame_decoder_macros
// assertion helpers shared by the decoder modules
// ----------------------------------------------------------------------------
`ifndef COBS_CRC16_FRAME_DECODER_MACROS_SVH
`define COBS_CRC16_FRAME_DECODER_MACROS_SVH

// condition must hold on every clock out of reset
`define COBSD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define COBSD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the cycle after the antecedent
`define COBSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cobsd_pkg.sv]
// ----------------------------------------------------------------------------
// cobsd_pkg
// shared types, constants and the crc step of the cobs frame decoder
// ----------------------------------------------------------------------------
package cobsd_pkg;

    localparam logic [7:0]  DELIM_BYTE          = 8'h00;
    localparam logic [7:0]  CODE_FULL           = 8'hFF;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY            = 16'h1021;
    localparam int          PAYLOAD_W           = 11;
    localparam logic [PAYLOAD_W-1:0] MAX_PAYLOAD_RESET = 11'd1024;
    localparam int          MAX_FRAME_BYTES_DEF = 2048;
    localparam int          QUEUE_DEPTH         = 2;
    localparam int          TDATA_W             = 24;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_CRC   = 3'd1,
        ST_COBS  = 3'd2,
        ST_SHORT = 3'd3,
        ST_LONG  = 3'd4
    } status_t;

    typedef enum logic {
        TOK_PUSH = 1'b0,
        TOK_END  = 1'b1
    } tok_kind_t;

    // work passed from the front end to the back end
    typedef struct packed {
        tok_kind_t  kind;
        logic [7:0] data;
        logic       long_err;
        logic       cobs_err;
    } token_t;

    // crc-16/ccitt-false, one byte, msb first
    function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
        begin
            if (c[15])
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

[rtl/cobsd_front.sv]
// ----------------------------------------------------------------------------
// cobsd_front
// accepts link bytes, undoes cobs grouping and issues decoded-byte and
// end-of-frame work items to the queue
// ----------------------------------------------------------------------------
module cobsd_front #(
    parameter int MAX_FRAME_BYTES = cobsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    input  logic              q_full,
    output logic              in_ready,
    output logic              q_push,
    output cobsd_pkg::token_t q_tok
);
    import cobsd_pkg::*;

    localparam int FB_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam logic [FB_W-1:0] FB_LIMIT = FB_W'(MAX_FRAME_BYTES);

    logic [7:0]      group_left_reg, group_left_next;
    logic            group_full_reg, group_full_next;
    logic            zero_pending_reg, zero_pending_next;
    logic [FB_W-1:0] frame_bytes_reg, frame_bytes_next;
    logic            err_reg, err_next;
    logic            take;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_left_reg   <= '0;
            group_full_reg   <= 1'b0;
            zero_pending_reg <= 1'b0;
            frame_bytes_reg  <= '0;
            err_reg          <= 1'b0;
        end
        else
        begin
            group_left_reg   <= group_left_next;
            group_full_reg   <= group_full_next;
            zero_pending_reg <= zero_pending_next;
            frame_bytes_reg  <= frame_bytes_next;
            err_reg          <= err_next;
        end
    end

    always_comb
    begin
        group_left_next   = group_left_reg;
        group_full_next   = group_full_reg;
        zero_pending_next = zero_pending_reg;
        frame_bytes_next  = frame_bytes_reg;
        err_next          = err_reg;
        q_push            = 1'b0;
        q_tok.kind        = TOK_PUSH;
        q_tok.data        = in_byte;
        q_tok.long_err    = err_reg;
        q_tok.cobs_err    = (group_left_reg != 8'd0);

        if (take)
        begin
            if (in_byte == DELIM_BYTE)
            begin
                // empty frames give nothing
                q_push            = (frame_bytes_reg != '0) || err_reg;
                q_tok.kind        = TOK_END;
                group_left_next   = '0;
                group_full_next   = 1'b0;
                zero_pending_next = 1'b0;
                frame_bytes_next  = '0;
                err_next          = 1'b0;
            end
            else if (err_reg)
            begin
                // rest of the frame is dropped
            end
            else if (frame_bytes_reg >= FB_LIMIT)
            begin
                err_next = 1'b1;
            end
            else
            begin
                frame_bytes_next = frame_bytes_reg + 1'b1;
                if (group_left_reg == 8'd0)
                begin
                    // code byte: implied zero of the previous group goes out now
                    q_push            = zero_pending_reg;
                    q_tok.data        = DELIM_BYTE;
                    group_left_next   = in_byte - 8'd1;
                    group_full_next   = (in_byte == CODE_FULL);
                    zero_pending_next = (in_byte == 8'd1);
                end
                else
                begin
                    q_push          = 1'b1;
                    group_left_next = group_left_reg - 8'd1;
                    if ((group_left_reg == 8'd1) && !group_full_reg)
                        zero_pending_next = 1'b1;
                end
            end
        end
    end

endmodule

[rtl/cobsd_queue.sv]
// ----------------------------------------------------------------------------
// cobsd_queue
// two-entry work queue between the front end and the back end
// ----------------------------------------------------------------------------
module cobsd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  cobsd_pkg::token_t push_tok,
    input  logic              pop,
    output logic              full,
    output logic              head_valid,
    output cobsd_pkg::token_t head_tok
);
    import cobsd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    token_t           mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_tok   = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_tok;
    end

endmodule

[rtl/cobsd_back.sv]
// ----------------------------------------------------------------------------
// cobsd_back
// two-byte delay line, crc accumulation, payload limit, frame status and
// the output register
// ----------------------------------------------------------------------------
`include "cobs_crc16_frame_decoder_macros.svh"

module cobsd_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tok_valid,
    input  cobsd_pkg::token_t                   tok,
    input  logic [cobsd_pkg::PAYLOAD_W-1:0]     max_payload,
    input  logic                                out_ready,
    output logic                                tok_pop,
    output logic                                out_valid,
    output logic                                out_kind,
    output logic [7:0]                          out_byte,
    output logic [2:0]                          out_status,
    output logic [cobsd_pkg::PAYLOAD_W-1:0]     out_len
);
    import cobsd_pkg::*;

    logic [7:0]           d0_reg, d0_next;
    logic [7:0]           d1_reg, d1_next;
    logic [1:0]           dcount_reg, dcount_next;
    logic [15:0]          crc_reg, crc_next;
    logic [PAYLOAD_W-1:0] pcount_reg, pcount_next;
    logic                 err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic [7:0]           out_byte_reg, out_byte_next;
    status_t              out_status_reg, out_status_next;
    logic [PAYLOAD_W-1:0] out_len_reg, out_len_next;

    logic                 take;
    logic                 emit;
    status_t              status;

    assign take    = tok_valid && (!out_valid_reg || out_ready);
    assign tok_pop = take;

    always_comb
    begin
        if (err_reg || tok.long_err)
            status = ST_LONG;
        else if (tok.cobs_err)
            status = ST_COBS;
        else if (dcount_reg != 2'd2)
            status = ST_SHORT;
        else if ({d1_reg, d0_reg} == crc_reg)
            status = ST_OK;
        else
            status = ST_CRC;
    end

    always_comb
    begin
        d0_next         = d0_reg;
        d1_next         = d1_reg;
        dcount_next     = dcount_reg;
        crc_next        = crc_reg;
        pcount_next     = pcount_reg;
        err_next        = err_reg;
        emit            = 1'b0;
        out_kind_next   = out_kind_reg;
        out_byte_next   = out_byte_reg;
        out_status_next = out_status_reg;
        out_len_next    = out_len_reg;

        if (take)
        begin
            case (tok.kind)
                TOK_END:
                begin
                    emit            = 1'b1;
                    out_kind_next   = 1'b1;
                    out_byte_next   = 8'h00;
                    out_status_next = status;
                    out_len_next    = pcount_reg;
                    dcount_next     = 2'd0;
                    d0_next         = 8'h00;
                    d1_next         = 8'h00;
                    crc_next        = CRC_INIT;
                    pcount_next     = '0;
                    err_next        = 1'b0;
                end
                TOK_PUSH:
                begin
                    if (err_reg)
                    begin
                        // frame already failed
                    end
                    else if (dcount_reg == 2'd0)
                    begin
                        d0_next     = tok.data;
                        dcount_next = 2'd1;
                    end
                    else if (dcount_reg == 2'd1)
                    begin
                        d1_next     = tok.data;
                        dcount_next = 2'd2;
                    end
                    else if (pcount_reg >= max_payload)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        // oldest byte leaves the delay line as payload
                        emit            = 1'b1;
                        out_kind_next   = 1'b0;
                        out_byte_next   = d0_reg;
                        out_status_next = ST_OK;
                        out_len_next    = '0;
                        crc_next        = crc_step(crc_reg, d0_reg);
                        pcount_next     = pcount_reg + 1'b1;
                        d0_next         = d1_reg;
                        d1_next         = tok.data;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (out_valid_reg && !out_ready)
            out_valid_next = 1'b1;
        else
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d0_reg        <= 8'h00;
            d1_reg        <= 8'h00;
            dcount_reg    <= 2'd0;
            crc_reg       <= CRC_INIT;
            pcount_reg    <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            d0_reg        <= d0_next;
            d1_reg        <= d1_next;
            dcount_reg    <= dcount_next;
            crc_reg       <= crc_next;
            pcount_reg    <= pcount_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg   <= out_kind_next;
        out_byte_reg   <= out_byte_next;
        out_status_reg <= out_status_next;
        out_len_reg    <= out_len_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_byte   = out_byte_reg;
    assign out_status = out_status_reg;
    assign out_len    = out_len_reg;

    // payload limit only trips with a full delay line
    `COBSD_ASSERT_IMPLIES(a_err_full_line, err_reg, dcount_reg == 2'd2,
        "payload error without full delay line")
    `COBSD_ASSERT_ALWAYS(a_dcount_range, dcount_reg != 2'd3,
        "delay line count out of range")
    `COBSD_ASSERT_IMPLIES(a_payload_clean, out_valid_reg && !out_kind_reg,
        (out_status_reg == ST_OK) && (out_len_reg == '0),
        "payload item carries status or length")
    `COBSD_ASSERT_NEXT(a_end_clears, take && (tok.kind == TOK_END),
        (dcount_reg == 2'd0) && (crc_reg == CRC_INIT) && (pcount_reg == '0) && !err_reg,
        "frame state not cleared after end of frame")

endmodule

[rtl/cobs_crc16_frame_decoder.sv]
// ----------------------------------------------------------------------------
// cobs_crc16_frame_decoder
// cobs frame decoder with crc-16/ccitt-false check, top level
// ----------------------------------------------------------------------------
// s_* channel: one received link byte per item, 0x00 marks the end of a frame.
// m_* channel: tentative payload bytes (tuser 0) and one end-of-frame status
// item per non-empty frame (tuser 1) carrying status and payload length.
// The consumer keeps a frame's payload bytes only if its status is ok.
// Throughput is one byte per cycle: the front end takes a byte every cycle the
// two-entry queue has room, and the back end drains one item a cycle while
// m_tready is high or its output register is empty. An accepted byte's result
// reaches m_tvalid through the queue write and then the output register; the
// last two decoded bytes of a frame are held as the received crc and never
// appear as payload. When m_tready is low the output register holds; the queue
// fills in two more items and then s_tready drops, with nothing lost.
// Reset clears all frame state and sets max_payload to 1024; no clearing
// pass is needed. max_payload is written through cfg_wr_en / cfg_wr_data; the user
// must write it only while no frame work is outstanding, which the block does not enforce.
// ----------------------------------------------------------------------------
module cobs_crc16_frame_decoder #(
    parameter int MAX_FRAME_BYTES = cobsd_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,     // [7:0] rx_byte
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [7:0] out_byte, [10:8] frame_status, [21:11] frame_payload_len, [23:22] zero
    output logic [cobsd_pkg::TDATA_W-1:0]      m_tdata,
    output logic                               m_tuser,     // [0] out_kind
    input  logic                               cfg_wr_en,
    input  logic [cobsd_pkg::PAYLOAD_W-1:0]    cfg_wr_data  // max_payload
);
    import cobsd_pkg::*;

    logic [PAYLOAD_W-1:0] max_payload_reg;
    logic                 q_push, q_full, q_pop, q_valid;
    token_t               q_in_tok, q_head_tok;
    logic                 out_kind;
    logic [7:0]           out_byte;
    logic [2:0]           out_status;
    logic [PAYLOAD_W-1:0] out_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_payload_reg <= MAX_PAYLOAD_RESET;
        else if (cfg_wr_en)
            max_payload_reg <= cfg_wr_data;
    end

    cobsd_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_byte  (s_tdata),
        .q_full   (q_full),
        .in_ready (s_tready),
        .q_push   (q_push),
        .q_tok    (q_in_tok)
    );

    cobsd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_tok   (q_in_tok),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_valid),
        .head_tok   (q_head_tok)
    );

    cobsd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .tok_valid   (q_valid),
        .tok         (q_head_tok),
        .max_payload (max_payload_reg),
        .out_ready   (m_tready),
        .tok_pop     (q_pop),
        .out_valid   (m_tvalid),
        .out_kind    (out_kind),
        .out_byte    (out_byte),
        .out_status  (out_status),
        .out_len     (out_len)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {2'b00, out_len, out_status, out_byte};

endmodule
